### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the wall collision core; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### src/cwcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwcf_pkg
// Shared types and constants of the circle wall collision force core.
// ----------------------------------------------------------------------------
package cwcf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH_DEF    = 4;

	// (1 << F) + restitution, wide enough for F up to 24
	localparam int KW  = 25;
	// quotient cap of the impulse magnitude
	localparam logic [34:0] IMP_CAP = 35'(1) << 34;

	typedef enum logic [2:0] {
		WALL_NONE   = 3'd0,
		WALL_RIGHT  = 3'd1,
		WALL_LEFT   = 3'd2,
		WALL_TOP    = 3'd3,
		WALL_BOTTOM = 3'd4
	} wall_t;

	typedef enum logic [1:0] {
		CFG_SCENE_W = 2'd0,
		CFG_SCENE_H = 2'd1,
		CFG_GRAV    = 2'd2,
		CFG_DT      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [30:0]        scene_w;
		logic [30:0]        scene_h;
		logic signed [31:0] grav;
		logic [30:0]        dt;      // never zero
	} cfg_t;

	// classified beat, front to back
	typedef struct packed {
		wall_t              wall;
		logic               on_x;
		logic signed [31:0] vn;
		logic signed [31:0] corr;
		logic               grav_en;
		logic [30:0]        mass;
		logic [30:0]        iner;
		logic [16:0]        e;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [62:0] gprod;   // mass * gravity_accel
	} item_t;

endpackage

### src/circle_wall_collision_force_core.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle; both dividers are fully pipelined, one quotient bit a stage.
// The output cannot be held off, so the queue never backs up and busy stays low in use.
// Reset (arst_n low, asynchronous) clears all valid bits and the queue, and loads the
// register defaults: scene 640.0 x 480.0, gravity 642908, dt 1092.
// ----------------------------------------------------------------------------
// circle_wall_collision_force_core
// Circle against the four scene walls: impulse force, resting force, clamp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module circle_wall_collision_force_core #(
	parameter int FRAC_BITS = cwcf_pkg::FRAC_BITS_DEF,
	parameter int QDEPTH    = cwcf_pkg::QDEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [31:0]         cfg_wdata,
	// command side
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  vel_x,
	input  logic signed [31:0]  vel_y,
	input  logic [30:0]         radius_in,
	input  logic [30:0]         body_mass,
	input  logic [30:0]         inertia,
	input  logic [16:0]         restitution,
	input  logic signed [31:0]  force_x_in,
	input  logic signed [31:0]  force_y_in,
	// result side: one beat per accepted command, strobed by done
	output logic                done,
	output logic signed [31:0]  force_x_out,
	output logic signed [31:0]  force_y_out,
	output logic [2:0]          wall_hit,
	output logic signed [31:0]  corrected_pos
);
	import cwcf_pkg::*;

	// ---- configuration registers
	logic [30:0]        scene_w_q, scene_h_q, dt_q;
	logic signed [31:0] grav_q;
	cfg_t               cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_w_q <= 31'd41943040;
			scene_h_q <= 31'd31457280;
			grav_q    <= 32'sd642908;
			dt_q      <= 31'd1092;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_SCENE_W: scene_w_q <= cfg_wdata[30:0];
				CFG_SCENE_H: scene_h_q <= cfg_wdata[30:0];
				CFG_GRAV:    grav_q    <= cfg_wdata;
				CFG_DT:      dt_q      <= cfg_wdata[30:0];
				default:     scene_w_q <= scene_w_q;
			endcase
		end
	end

	// a zero time step counts as one LSB
	always_comb begin
		cfg.scene_w = scene_w_q;
		cfg.scene_h = scene_h_q;
		cfg.grav    = grav_q;
		cfg.dt      = (dt_q == '0) ? 31'd1 : dt_q;
	end

	// ---- front: wall classification
	logic  take, front_vld;
	item_t front_item;
	logic  q_nonempty, q_nearly_full;
	item_t q_head;

	assign take = start && !busy;
	assign busy = q_nearly_full;

	cwcf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.take       (take),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.radius_in  (radius_in),
		.body_mass  (body_mass),
		.inertia    (inertia),
		.restitution(restitution),
		.force_x_in (force_x_in),
		.force_y_in (force_y_in),
		.vld_s1     (front_vld),
		.item_s1    (front_item)
	);

	// ---- queue: the back end drains one beat every cycle
	cwcf_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_vld),
		.push_item  (front_item),
		.pop        (q_nonempty),
		.nonempty   (q_nonempty),
		.nearly_full(q_nearly_full),
		.head       (q_head)
	);

	// ---- back: effective mass, impulse, sums
	cwcf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (q_nonempty),
		.in_item      (q_head),
		.done         (done),
		.force_x_out  (force_x_out),
		.force_y_out  (force_y_out),
		.wall_hit     (wall_hit),
		.corrected_pos(corrected_pos)
	);

	// no wall means no clamp
	`ASSERT_CLK(a_nowall_zero_pos, clk, arst_n, (done && (wall_hit == WALL_NONE)) |-> (corrected_pos == 32'sd0), "corrected_pos set with no wall")
	// a command taken always reaches the queue in the next cycle
	`ASSERT_CLK(a_take_to_queue, clk, arst_n, take |=> front_vld, "accepted beat lost before queue")

endmodule

### src/cwcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwcf_front
// Wall tests, clamped coordinate, normal velocity and resting force product.
// ----------------------------------------------------------------------------
module cwcf_front #(
	parameter int FRAC_BITS = cwcf_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cwcf_pkg::cfg_t      cfg,
	input  logic                take,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  vel_x,
	input  logic signed [31:0]  vel_y,
	input  logic [30:0]         radius_in,
	input  logic [30:0]         body_mass,
	input  logic [30:0]         inertia,
	input  logic [16:0]         restitution,
	input  logic signed [31:0]  force_x_in,
	input  logic signed [31:0]  force_y_in,
	output logic                vld_s1,
	output cwcf_pkg::item_t     item_s1
);
	import cwcf_pkg::*;

	// 0.01 in fixed point, rounded
	localparam int SLOW_VEL = ((1 << FRAC_BITS) + 50) / 100;

	logic signed [33:0] r34, px34, py34, dx, dy;
	logic signed [63:0] gp;
	item_t              it;

	always_comb begin
		r34  = $signed({3'b000, radius_in});
		px34 = 34'(pos_x);
		py34 = 34'(pos_y);
		dx   = $signed({3'b000, cfg.scene_w}) - px34;
		dy   = $signed({3'b000, cfg.scene_h}) - py34;
		gp   = $signed({1'b0, body_mass}) * cfg.grav;

		it         = '0;
		it.mass    = body_mass;
		it.iner    = inertia;
		it.e       = restitution;
		it.fx      = force_x_in;
		it.fy      = force_y_in;
		it.gprod   = gp[62:0];
		it.wall    = WALL_NONE;
		priority if (dx <= r34) begin
			it.wall = WALL_RIGHT;
			it.on_x = 1'b1;
			it.corr = $signed({1'b0, cfg.scene_w}) - $signed({1'b0, radius_in});
			it.vn   = (vel_x > 32'sd0) ? vel_x : 32'sd0;
		end else if (px34 <= r34) begin
			it.wall = WALL_LEFT;
			it.on_x = 1'b1;
			it.corr = $signed({1'b0, radius_in});
			it.vn   = (vel_x < 32'sd0) ? vel_x : 32'sd0;
		end else if (dy <= r34) begin
			it.wall = WALL_TOP;
			it.corr = $signed({1'b0, cfg.scene_h}) - $signed({1'b0, radius_in});
			it.vn   = (vel_y > 32'sd0) ? vel_y : 32'sd0;
		end else if (py34 <= r34) begin
			it.wall    = WALL_BOTTOM;
			it.corr    = $signed({1'b0, radius_in});
			it.vn      = (vel_y < 32'sd0) ? vel_y : 32'sd0;
			// resting contact: slow upward or still
			it.grav_en = (vel_y >= 32'sd0) && (vel_y < $signed(32'(SLOW_VEL)));
		end else begin
			it.wall = WALL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= it;
		end
	end

endmodule

### src/cwcf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwcf_queue
// Short FIFO between the classifier and the arithmetic back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cwcf_queue #(
	parameter int DEPTH = cwcf_pkg::QDEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cwcf_pkg::item_t  push_item,
	input  logic             pop,
	output logic             nonempty,
	output logic             nearly_full,
	output cwcf_pkg::item_t  head
);
	import cwcf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign do_pop      = pop && (cnt_q != '0);
	assign nonempty    = (cnt_q != '0);
	// one beat may still sit in the front register
	assign nearly_full = (cnt_q >= CW'(DEPTH - 1));
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && !do_pop && (cnt_q == CW'(DEPTH)), "queue overflow")

endmodule

### src/cwcf_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwcf_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cwcf_div_pipe #(
	parameter int DW = 32,
	parameter int QW = 31,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] in_hi,     // upper dividend, below in_d
	input  logic [QW-1:0] in_lo,
	input  logic [DW-1:0] in_d,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [QW-1:0] out_q,
	output logic [PW-1:0] out_pay
);

	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] lo_s  [0:QW];   // dividend bits shift out, quotient bits shift in
	logic [DW-1:0] d_s   [0:QW];
	logic [PW-1:0] pay_s [0:QW];
	logic [QW:0]   vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QW-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= in_hi;
		lo_s[0]  <= in_lo;
		d_s[0]   <= in_d;
		pay_s[0] <= in_pay;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] t;
		logic        ge;
		always_comb begin
			t  = {rem_s[k], lo_s[k][QW-1]};
			ge = (t >= {1'b0, d_s[k]});
		end
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? DW'(t - {1'b0, d_s[k]}) : t[DW-1:0];
			lo_s[k+1]  <= {lo_s[k][QW-2:0], ge};
			d_s[k+1]   <= d_s[k];
			pay_s[k+1] <= pay_s[k];
		end
	end

	assign out_valid = vld_s[QW];
	assign out_q     = lo_s[QW];
	assign out_pay   = pay_s[QW];

	`ASSERT_NEVER(a_hi_below_d, clk, arst_n, in_valid && (in_d != '0) && (in_hi >= in_d), "dividend too large for quotient width")

endmodule

### src/cwcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwcf_back
// Effective mass, impulse division, force sums and saturation.
// ----------------------------------------------------------------------------
module cwcf_back #(
	parameter int FRAC_BITS = cwcf_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cwcf_pkg::cfg_t      cfg,
	input  logic                in_valid,
	input  cwcf_pkg::item_t     in_item,
	output logic                done,
	output logic signed [31:0]  force_x_out,
	output logic signed [31:0]  force_y_out,
	output logic [2:0]          wall_hit,
	output logic signed [31:0]  corrected_pos
);
	import cwcf_pkg::*;

	localparam logic [KW-1:0] K_ONE = KW'(1) << FRAC_BITS;

	typedef struct packed {
		logic               msum_zero;
		logic [31:0]        av;
		logic               vpos;
		logic [16:0]        e;
		logic signed [55:0] grav;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic               on_x;
		wall_t              wall;
		logic signed [31:0] corr;
	} pay1_t;

	typedef struct packed {
		logic               ovf;
		logic               vpos;
		logic signed [55:0] grav;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic               on_x;
		wall_t              wall;
		logic signed [31:0] corr;
	} pay2_t;

	// ---- entry stage: gravity term, mass product and sum, |vn|
	logic [62:0]  gmag, gsh;
	logic         vld_s1;
	logic [61:0]  mi_s1;
	logic [31:0]  msum_s1;
	pay1_t        p_s1;

	always_comb begin
		gmag = in_item.gprod[62] ? 63'(-in_item.gprod) : 63'(in_item.gprod);
		gsh  = gmag >> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mi_s1          <= in_item.mass * in_item.iner;
		msum_s1        <= {1'b0, in_item.mass} + {1'b0, in_item.iner};
		p_s1.msum_zero <= (in_item.mass == '0) && (in_item.iner == '0);
		p_s1.av        <= in_item.vn[31] ? 32'(-in_item.vn) : 32'(in_item.vn);
		p_s1.vpos      <= (in_item.vn > 32'sd0);
		p_s1.e         <= in_item.e;
		if (!in_item.grav_en) begin
			p_s1.grav <= '0;
		end else if (in_item.gprod[62]) begin
			p_s1.grav <= -$signed({1'b0, gsh[54:0]});
		end else begin
			p_s1.grav <= $signed({1'b0, gsh[54:0]});
		end
		p_s1.fx   <= in_item.fx;
		p_s1.fy   <= in_item.fy;
		p_s1.on_x <= in_item.on_x;
		p_s1.wall <= in_item.wall;
		p_s1.corr <= in_item.corr;
	end

	// ---- effective mass m = mass*inertia / (mass+inertia)
	logic                 d1_vld;
	logic [30:0]          d1_q;
	logic [$bits(pay1_t)-1:0] d1_pay;

	cwcf_div_pipe #(.DW(32), .QW(31), .PW($bits(pay1_t))) u_div_mass (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_hi    ({1'b0, mi_s1[61:31]}),
		.in_lo    (mi_s1[30:0]),
		.in_d     (msum_s1),
		.in_pay   (p_s1),
		.out_valid(d1_vld),
		.out_q    (d1_q),
		.out_pay  (d1_pay)
	);

	pay1_t       d1_p;
	logic [30:0] m_eff;
	assign d1_p  = pay1_t'(d1_pay);
	assign m_eff = d1_p.msum_zero ? '0 : d1_q;

	// ---- |vn| * m
	logic        vld_s2;
	logic [62:0] avm_s2;
	pay1_t       p_s2;

	always_ff @(posedge clk) begin
		avm_s2 <= d1_p.av * m_eff;
		p_s2   <= d1_p;
	end

	// ---- times (1 + e), in two partial products
	logic          vld_s3;
	logic [55:0]   lo_s3;
	logic [56:0]   hi_s3;
	pay1_t         p_s3;
	logic [KW-1:0] kk;

	assign kk = K_ONE + KW'(p_s2.e);

	always_ff @(posedge clk) begin
		lo_s3 <= avm_s2[30:0] * kk;
		hi_s3 <= avm_s2[62:31] * kk;
		p_s3  <= p_s2;
	end

	// ---- scale down by 2^F, check the quotient cap
	logic [87:0] prod, pscl;
	logic [52:0] ptop;
	logic        ovf;
	logic        vld_s4;
	logic [30:0] hi_s4;
	logic [34:0] lo_s4;
	pay2_t       p_s4;

	always_comb begin
		prod = {hi_s3, 31'b0} + 88'(lo_s3);
		pscl = prod >> FRAC_BITS;
		ptop = pscl[87:35];
		ovf  = (ptop >= 53'(cfg.dt));
	end

	always_ff @(posedge clk) begin
		hi_s4     <= ovf ? '0 : ptop[30:0];
		lo_s4     <= ovf ? '0 : pscl[34:0];
		p_s4.ovf  <= ovf;
		p_s4.vpos <= p_s3.vpos;
		p_s4.grav <= p_s3.grav;
		p_s4.fx   <= p_s3.fx;
		p_s4.fy   <= p_s3.fy;
		p_s4.on_x <= p_s3.on_x;
		p_s4.wall <= p_s3.wall;
		p_s4.corr <= p_s3.corr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= d1_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// ---- impulse magnitude = scaled product / dt
	logic                     d2_vld;
	logic [34:0]              d2_q;
	logic [$bits(pay2_t)-1:0] d2_pay;

	cwcf_div_pipe #(.DW(31), .QW(35), .PW($bits(pay2_t))) u_div_dt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s4),
		.in_hi    (hi_s4),
		.in_lo    (lo_s4),
		.in_d     (cfg.dt),
		.in_pay   (p_s4),
		.out_valid(d2_vld),
		.out_q    (d2_q),
		.out_pay  (d2_pay)
	);

	// ---- sums and saturation
	pay2_t              d2_p;
	logic [34:0]        qc;
	logic signed [35:0] imp;
	logic signed [63:0] sx, sy;
	logic signed [31:0] fx_sat, fy_sat;

	always_comb begin
		d2_p = pay2_t'(d2_pay);
		qc   = (d2_p.ovf || (d2_q > IMP_CAP)) ? IMP_CAP : d2_q;
		imp  = d2_p.vpos ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
		sx   = 64'(d2_p.fx) + (d2_p.on_x ? 64'(imp) : 64'sd0);
		sy   = 64'(d2_p.fy) + (d2_p.on_x ? 64'sd0 : 64'(imp)) + 64'(d2_p.grav);
		if (sx > 64'sd2147483647) begin
			fx_sat = 32'sh7FFFFFFF;
		end else if (sx < -64'sd2147483648) begin
			fx_sat = 32'sh80000000;
		end else begin
			fx_sat = sx[31:0];
		end
		if (sy > 64'sd2147483647) begin
			fy_sat = 32'sh7FFFFFFF;
		end else if (sy < -64'sd2147483648) begin
			fy_sat = 32'sh80000000;
		end else begin
			fy_sat = sy[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		force_x_out   <= fx_sat;
		force_y_out   <= fy_sat;
		wall_hit      <= d2_p.wall;
		corrected_pos <= d2_p.corr;
	end

endmodule

### tb/circle_wall_collision_force_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_wall_collision_force_core_tb
// Self-checking bench: directed wall and corner cases, then random bodies
// under several scene settings; every result beat is checked in order.
// ----------------------------------------------------------------------------
module circle_wall_collision_force_core_tb;
	import cwcf_pkg::*;

	localparam int F        = 16;
	localparam int LATENCY  = 75;
	localparam int WDOG_MAX = 5000;
	localparam longint SLOW = (64'd65536 + 50) / 100;

	typedef struct {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		wall_t              wall;
		logic signed [31:0] corr;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = CFG_SCENE_W;
	logic [31:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
	logic [30:0] radius_in = '0, body_mass = '0, inertia = '0;
	logic [16:0] restitution = '0;
	logic signed [31:0] force_x_in = '0, force_y_in = '0;
	logic done;
	logic signed [31:0] force_x_out, force_y_out, corrected_pos;
	logic [2:0] wall_hit;

	// shadow copy of the register file
	longint scene_w = 41943040, scene_h = 31457280, grav_acc = 642908, dt_reg = 1092;

	contact_t expected_q[$];
	int n_sent = 0, n_checked = 0, n_errors = 0, idle_cycles = 0;

	circle_wall_collision_force_core u_dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// saturate to 32-bit signed
	function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// expected response of one body against the walls
	function automatic contact_t wall_response(
			longint px, longint py, longint vx, longint vy, longint r,
			longint mass, longint iner, longint e, longint fx, longint fy);
		contact_t c;
		longint vn, corr, grav, m, dt, gp;
		logic on_x;
		logic [127:0] num, q;
		logic signed [127:0] imp, sfx, sfy;
		vn = 0; corr = 0; grav = 0; on_x = 1'b0; c.wall = WALL_NONE;
		if (scene_w - px <= r) begin
			c.wall = WALL_RIGHT; on_x = 1'b1; corr = scene_w - r;
			if (vx > 0) vn = vx;
		end else if (px <= r) begin
			c.wall = WALL_LEFT; on_x = 1'b1; corr = r;
			if (vx < 0) vn = vx;
		end else if (scene_h - py <= r) begin
			c.wall = WALL_TOP; corr = scene_h - r;
			if (vy > 0) vn = vy;
		end else if (py <= r) begin
			c.wall = WALL_BOTTOM; corr = r;
			if (vy < 0) vn = vy;
			else if (vy < SLOW) begin
				gp = mass * grav_acc;
				grav = (gp < 0) ? -((-gp) >>> F) : (gp >>> F);
			end
		end
		m = (mass + iner == 0) ? 0 : (mass * iner) / (mass + iner);
		dt = (dt_reg == 0) ? 1 : dt_reg;
		imp = 0;
		if (vn != 0 && m != 0) begin
			num = 128'((65536 + e) * (vn < 0 ? -vn : vn)) * 128'(m);
			q = num / (128'(dt) << F);
			if (q > (128'd1 << 34)) q = 128'd1 << 34;
			imp = (vn > 0) ? -$signed(q) : $signed(q);
		end
		sfx = fx; sfy = fy + grav;
		if (on_x) sfx += imp; else sfy += imp;
		c.fx = clamp32(sfx);
		c.fy = clamp32(sfy);
		c.corr = corr[31:0];
		return c;
	endfunction

	// random gap: mostly none or short, now and then long; start drops only
	// when there really is a gap
	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 99);
		n = (n < 55) ? 0 : (n < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// send one body; one beat is taken at the next rising edge with busy low
	task automatic send_body(logic signed [31:0] px, py, vx, vy,
			logic [30:0] r, mass, iner, logic [16:0] e, logic signed [31:0] fx, fy);
		pos_x <= px; pos_y <= py; vel_x <= vx; vel_y <= vy;
		radius_in <= r; body_mass <= mass; inertia <= iner; restitution <= e;
		force_x_in <= fx; force_y_in <= fy; start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(wall_response(px, py, vx, vy, r, mass, iner, e, fx, fy));
		n_sent++;
		@(negedge clk);
		if ($urandom_range(0, 3) != 0) begin
			idle_gap();
		end
	endtask

	task automatic end_burst();
		start <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every expected beat, then the pipeline depth
	task automatic drain();
		end_burst();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SCENE_W: scene_w = val[30:0];
			CFG_SCENE_H: scene_h = val[30:0];
			CFG_GRAV:    grav_acc = longint'($signed(val));
			CFG_DT:      dt_reg = val[30:0];
		endcase
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd_wide();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// results are checked at the rising edge they are presented on
	always @(posedge clk) begin
		contact_t c;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				n_errors++;
			end else begin
				c = expected_q.pop_front();
				n_checked++;
				if (force_x_out !== c.fx || force_y_out !== c.fy ||
						wall_hit !== c.wall || corrected_pos !== c.corr) begin
					$display("%0t: mismatch exp fx=%0d fy=%0d wall=%0d pos=%0d",
						$time, c.fx, c.fy, c.wall, c.corr);
					$display("%0t:          got fx=%0d fy=%0d wall=%0d pos=%0d",
						$time, force_x_out, force_y_out, wall_hit, corrected_pos);
					n_errors++;
				end
			end
		end
	end

	// watchdog on cycles with no command taken, no result and no register write
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_MAX) begin
			$display("[circle_wall_collision_force_core] ERROR");
			$finish;
		end
	end

	// one contact per wall, both velocity senses on the side walls, plus corner priority and a free body
	task automatic test_walls();
		send_body(32'sd41943000, 32'sd20000000, 32'sd300000, 0, 31'd655360,
			31'd65536, 31'd65536, 17'd65536, 0, 0);
		send_body(32'sd41943000, 32'sd20000000, -32'sd300000, 0, 31'd655360,
			31'd65536, 31'd65536, 17'd32768, 5, 7);
		send_body(32'sd100, 32'sd20000000, -32'sd500000, 0, 31'd655360,
			31'd131072, 31'd65536, 17'd0, 0, 0);
		send_body(32'sd100, 32'sd100, 32'sd500000, 0, 31'd655360,
			31'd131072, 31'd65536, 17'd0, 0, 0);
		send_body(32'sd20000000, 32'sd31457000, 0, 32'sd700000, 31'd655360,
			31'd65536, 31'd196608, 17'd65536, 0, 0);
		send_body(32'sd20000000, 32'sd1000, 0, -32'sd700000, 31'd655360,
			31'd65536, 31'd196608, 17'd65536, 0, 0);
		send_body(32'sd20000000, 32'sd20000000, 32'sd1, 32'sd1, 31'd655360,
			31'd65536, 31'd65536, 17'd65536, 32'sd123, -32'sd456);
		end_burst();
	endtask

	// slow bottom contact: resting force below the threshold, none at it
	task automatic test_resting();
		send_body(32'sd20000000, 32'sd10, 0, 0, 31'd655360, 31'd655360, 31'd65536, 0, 0, 0);
		send_body(32'sd20000000, 32'sd10, 0, 32'(SLOW - 1), 31'd655360,
			31'h7fffffff, 31'd65536, 0, 0, 32'sh7fffff00);
		send_body(32'sd20000000, 32'sd10, 0, 32'(SLOW), 31'd655360,
			31'd655360, 31'd65536, 0, 0, 0);
		end_burst();
	endtask

	// extremes: zero mass sum, saturation, restitution above one
	task automatic test_extremes();
		send_body(32'sd41943000, 0, 32'sd300000, 0, 31'd655360, 0, 0, 17'd65536, 0, 0);
		send_body(32'sh7fffffff, 0, 32'sh7fffffff, 0, 31'h7fffffff,
			31'h7fffffff, 31'h7fffffff, 17'h1ffff, 32'sh7fffffff, 0);
		send_body(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0,
			31'h7fffffff, 31'h7fffffff, 17'h1ffff, 32'sh80000000, 32'sh80000000);
		send_body(32'sd20000000, 32'sh80000000, 0, 32'sh80000000, 0,
			31'h7fffffff, 31'd1, 17'd0, 0, 32'sh80000000);
		drain();
	endtask

	// register extremes, including a zero time step and negative gravity
	task automatic test_registers();
		write_reg(CFG_DT, 32'd0);
		write_reg(CFG_GRAV, 32'h80000000);
		send_body(32'sd41943000, 0, 32'sd300000, 0, 31'd655360, 31'd65536,
			31'd65536, 17'd65536, 0, 0);
		send_body(32'sd20000000, 32'sd10, 0, 0, 31'd655360, 31'h7fffffff,
			31'd65536, 0, 0, 0);
		drain();
		write_reg(CFG_SCENE_W, 32'hffffffff);
		write_reg(CFG_SCENE_H, 32'd0);
		write_reg(CFG_GRAV, 32'h7fffffff);
		write_reg(CFG_DT, 32'h7fffffff);
		send_body(32'sd10, 32'sd10, 32'sd5, 32'sd5, 31'd655360, 31'd65536,
			31'd65536, 17'd65536, 0, 0);
		send_body(32'sh7fffffff, 32'sd5, -32'sd5, 32'sd5, 31'd0, 31'd65536,
			31'd65536, 17'd65536, 0, 0);
		drain();
	endtask

	// random bodies; mostly positions near a wall so contacts are common
	task automatic test_random(int n);
		logic [31:0] px, py;
		logic [30:0] r;
		for (int i = 0; i < n; i++) begin
			r = ($urandom_range(0, 9) == 0) ? 31'(rnd_wide()) :
				31'($urandom_range(0, 2000000));
			case ($urandom_range(0, 5))
				0: px = 32'(scene_w) - $urandom_range(0, 3000000);
				1: px = $urandom_range(0, 3000000);
				default: px = 32'(scene_w / 2) + $urandom_range(0, 1000000);
			endcase
			case ($urandom_range(0, 4))
				0: py = 32'(scene_h) - $urandom_range(0, 3000000);
				1: py = $urandom_range(0, 3000000);
				default: py = 32'(scene_h / 2);
			endcase
			if ($urandom_range(0, 9) == 0) begin
				px = rnd_wide(); py = rnd_wide();
			end
			send_body(px, py,
				($urandom_range(0, 3) == 0) ? rnd_wide() : $signed($urandom_range(0, 2000000)) - 1000000,
				($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 1400)) - 700 :
					($urandom_range(0, 2) == 0) ? rnd_wide() : $signed($urandom_range(0, 2000000)) - 1000000,
				r,
				($urandom_range(0, 4) == 0) ? 31'(rnd_wide()) : 31'($urandom_range(0, 4000000)),
				($urandom_range(0, 4) == 0) ? 31'(rnd_wide()) : 31'($urandom_range(0, 4000000)),
				($urandom_range(0, 7) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536)),
				rnd_wide(), rnd_wide());
		end
		drain();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_walls();
		test_resting();
		test_extremes();
		test_registers();
		write_reg(CFG_SCENE_W, 32'd41943040);
		write_reg(CFG_SCENE_H, 32'd31457280);
		write_reg(CFG_GRAV, 32'd642908);
		write_reg(CFG_DT, 32'd1092);
		test_random(500);
		write_reg(CFG_SCENE_W, 32'd6553600);
		write_reg(CFG_SCENE_H, 32'd3276800);
		write_reg(CFG_GRAV, -32'sd1000000);
		write_reg(CFG_DT, 32'd1);
		test_random(450);
		write_reg(CFG_SCENE_W, $urandom());
		write_reg(CFG_SCENE_H, $urandom());
		write_reg(CFG_GRAV, $urandom());
		write_reg(CFG_DT, $urandom_range(1, 200000));
		test_random(480);
		$display("Sent %0d bodies over four scene settings, %0d results checked, %0d errors.",
			n_sent, n_checked, n_errors);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("[circle_wall_collision_force_core] OK");
		else
			$display("[circle_wall_collision_force_core] ERROR");
		$finish;
	end

endmodule
